/* rtl/dsf_pkg.sv */
package dsf_pkg;

   localparam int unsigned HdrBytes = 5;

   typedef enum logic [3:0] {
      MODE_STATUS        = 4'd0,
      MODE_BUF_WRITE     = 4'd1,
      MODE_BUF_READ      = 4'd2,
      MODE_PAGE_READ     = 4'd3,
      MODE_PAGE_TO_BUF   = 4'd4,
      MODE_BUF_TO_PAGE   = 4'd5,
      MODE_BUF_TO_PAGE_NE = 4'd6,
      MODE_PAGE_ERASE    = 4'd7,
      MODE_BLOCK_ERASE   = 4'd8,
      MODE_CHIP_ERASE    = 4'd9,
      MODE_BUF_PROG      = 4'd10,
      MODE_DATA          = 4'd11
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_FRAME   = 2'd1,
      STAT_FRAME_OPEN = 2'd2
   } status_type;

   localparam logic [7:0] OP_STATUS      = 8'hD7;
   localparam logic [7:0] OP_BUF1_WRITE  = 8'h84;
   localparam logic [7:0] OP_BUF2_WRITE  = 8'h87;
   localparam logic [7:0] OP_BUF1_READ   = 8'hD1;
   localparam logic [7:0] OP_BUF2_READ   = 8'hD3;
   localparam logic [7:0] OP_PAGE_READ   = 8'h03;
   localparam logic [7:0] OP_PG_TO_BUF1  = 8'h53;
   localparam logic [7:0] OP_PG_TO_BUF2  = 8'h55;
   localparam logic [7:0] OP_BUF1_TO_PG  = 8'h83;
   localparam logic [7:0] OP_BUF2_TO_PG  = 8'h86;
   localparam logic [7:0] OP_BUF1_TO_PGN = 8'h88;
   localparam logic [7:0] OP_BUF2_TO_PGN = 8'h89;
   localparam logic [7:0] OP_PAGE_ERASE  = 8'h81;
   localparam logic [7:0] OP_BLOCK_ERASE = 8'h50;
   localparam logic [7:0] OP_BUF1_PROG   = 8'h82;
   localparam logic [7:0] OP_BUF2_PROG   = 8'h85;
   localparam logic [7:0] CHIP_ERASE_0   = 8'hC7;
   localparam logic [7:0] CHIP_ERASE_1   = 8'h94;
   localparam logic [7:0] CHIP_ERASE_2   = 8'h80;
   localparam logic [7:0] CHIP_ERASE_3   = 8'h9A;
   localparam logic [7:0] DUMMY_BYTE     = 8'hFF;

   // One run of result bytes caused by a single input item
   typedef struct packed {
      logic                          present;
      logic [HdrBytes-1:0][7:0]      bytes;
      logic [2:0]                    count;
      logic                          start_first;
      logic                          release_last;
      status_type                    status;
   } run_type;

endpackage

/* rtl/dsf_header.sv */
module dsf_header (
   input  logic [3:0]        mode,
   input  logic              buffer_sel,
   input  logic [11:0]       page,
   input  logic [9:0]        byte_addr,
   input  logic [7:0]        data_byte,
   input  logic              end_of_frame,
   input  logic              frame_open,
   output dsf_pkg::run_type  run,
   output logic              frame_open_in
);

   logic [7:0] p1;
   logic [7:0] p0;
   logic [7:0] ah;
   logic [7:0] al;
   logic       stay_open;

   assign p1 = {2'b00, page[11:6]};
   assign p0 = {page[5:0], 2'b00};
   assign ah = {6'b000000, byte_addr[9:8]};
   assign al = byte_addr[7:0];

   always_comb begin
      run           = '0;
      run.present   = 1'b1;
      run.count     = 3'd1;
      run.status    = dsf_pkg::STAT_OK;
      frame_open_in = frame_open;
      stay_open     = 1'b0;
      if (mode == dsf_pkg::MODE_DATA) begin
         if (!frame_open) begin
            run.status = dsf_pkg::STAT_NO_FRAME;
         end else begin
            run.bytes[0]     = data_byte;
            run.release_last = end_of_frame;
            frame_open_in    = ~end_of_frame;
         end
      end else if (mode > dsf_pkg::MODE_DATA) begin
         // undefined codes: drop the item
         run.present = 1'b0;
      end else if (frame_open) begin
         run.status = dsf_pkg::STAT_FRAME_OPEN;
      end else begin
         run.start_first = 1'b1;
         run.count       = 3'd4;
         case (dsf_pkg::mode_type'(mode))
            dsf_pkg::MODE_STATUS: begin
               run.bytes[0] = dsf_pkg::OP_STATUS;
               run.bytes[1] = dsf_pkg::DUMMY_BYTE;
               run.count    = 3'd2;
            end
            dsf_pkg::MODE_BUF_WRITE: begin
               run.bytes[0] = buffer_sel ? dsf_pkg::OP_BUF2_WRITE : dsf_pkg::OP_BUF1_WRITE;
               run.bytes[2] = ah;
               run.bytes[3] = al;
               stay_open    = 1'b1;
            end
            dsf_pkg::MODE_BUF_READ: begin
               run.bytes[0] = buffer_sel ? dsf_pkg::OP_BUF2_READ : dsf_pkg::OP_BUF1_READ;
               run.bytes[2] = ah;
               run.bytes[3] = al;
               run.bytes[4] = dsf_pkg::DUMMY_BYTE;
               run.count    = 3'd5;
               stay_open    = 1'b1;
            end
            dsf_pkg::MODE_PAGE_READ: begin
               run.bytes[0] = dsf_pkg::OP_PAGE_READ;
               run.bytes[1] = p1;
               run.bytes[2] = p0 | ah;
               run.bytes[3] = al;
               stay_open    = 1'b1;
            end
            dsf_pkg::MODE_PAGE_TO_BUF: begin
               run.bytes[0] = buffer_sel ? dsf_pkg::OP_PG_TO_BUF2 : dsf_pkg::OP_PG_TO_BUF1;
               run.bytes[1] = p1;
               run.bytes[2] = p0;
            end
            dsf_pkg::MODE_BUF_TO_PAGE: begin
               run.bytes[0] = buffer_sel ? dsf_pkg::OP_BUF2_TO_PG : dsf_pkg::OP_BUF1_TO_PG;
               run.bytes[1] = p1;
               run.bytes[2] = p0;
            end
            dsf_pkg::MODE_BUF_TO_PAGE_NE: begin
               run.bytes[0] = buffer_sel ? dsf_pkg::OP_BUF2_TO_PGN : dsf_pkg::OP_BUF1_TO_PGN;
               run.bytes[1] = p1;
               run.bytes[2] = p0;
            end
            dsf_pkg::MODE_PAGE_ERASE: begin
               run.bytes[0] = dsf_pkg::OP_PAGE_ERASE;
               run.bytes[1] = p1;
               run.bytes[2] = p0;
            end
            dsf_pkg::MODE_BLOCK_ERASE: begin
               run.bytes[0] = dsf_pkg::OP_BLOCK_ERASE;
               run.bytes[1] = p1;
               run.bytes[2] = p0;
            end
            dsf_pkg::MODE_CHIP_ERASE: begin
               run.bytes[0] = dsf_pkg::CHIP_ERASE_0;
               run.bytes[1] = dsf_pkg::CHIP_ERASE_1;
               run.bytes[2] = dsf_pkg::CHIP_ERASE_2;
               run.bytes[3] = dsf_pkg::CHIP_ERASE_3;
            end
            default: begin
               run.bytes[0] = buffer_sel ? dsf_pkg::OP_BUF2_PROG : dsf_pkg::OP_BUF1_PROG;
               run.bytes[1] = p1;
               run.bytes[2] = p0 | ah;
               run.bytes[3] = al;
               stay_open    = 1'b1;
            end
         endcase
         run.release_last = ~stay_open;
         frame_open_in    = stay_open;
      end
   end

endmodule

/* rtl/dsf_emitter.sv */
module dsf_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dsf_pkg::run_type  run,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_spi_byte,
   output logic              rsp_frame_start,
   output logic              rsp_release_select,
   output logic              rsp_last_of_run,
   output logic [1:0]        rsp_status
);

   dsf_pkg::run_type run_ff, run_in;
   logic             busy_ff, busy_in;
   logic [2:0]       idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             start_ff, start_in;
   logic             rel_ff, rel_in;
   logic             last_ff, last_in;
   logic [1:0]       status_ff, status_in;
   logic             out_move;
   logic             emit;
   logic             at_last;

   always_comb begin
      out_move  = ~valid_ff | ~rsp_stall;
      emit      = busy_ff & out_move;
      at_last   = (idx_ff == (run_ff.count - 3'd1));
      ready     = ~busy_ff | (emit & at_last);
      run_in    = run_ff;
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      start_in  = start_ff;
      rel_in    = rel_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (emit) begin
         idx_in = idx_ff + 3'd1;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         run_in  = run;
         busy_in = 1'b1;
         idx_in  = '0;
      end
      if (out_move) begin
         valid_in  = busy_ff;
         byte_in   = run_ff.bytes[idx_ff];
         start_in  = run_ff.start_first & (idx_ff == 3'd0);
         rel_in    = run_ff.release_last & at_last;
         last_in   = at_last;
         status_in = run_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      run_ff    <= run_in;
      byte_ff   <= byte_in;
      start_ff  <= start_in;
      rel_ff    <= rel_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_spi_byte       = byte_ff;
   assign rsp_frame_start    = start_ff;
   assign rsp_release_select = rel_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_status         = status_ff;

endmodule

/* rtl/dataflash_spi_command_framer.sv */
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall mode, buffer_sel, page, byte_addr, data_byte,
//                                         end_of_frame
// rsp      out        rsp_valid/rsp_stall spi_byte, frame_start, release_select,
//                                         last_of_run, status
//
// An item yields its run of result bytes: five for a buffer read, four for most
// commands, two for status read, one for a data byte or an error; the run register in
// the emitter hands out one byte a cycle unless rsp stalls. An undefined mode is taken
// but produces nothing. Each byte passes the run register, then the output register.
// Reset is synchronous: it closes any open frame and empties both stages.
// A stall on rsp holds the output and run registers; req_stall stays high until the
// last byte of the current run moves on.
module dataflash_spi_command_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_mode,
   input  logic        req_buffer_sel,
   input  logic [11:0] req_page,
   input  logic [9:0]  req_byte_addr,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_spi_byte,
   output logic        rsp_frame_start,
   output logic        rsp_release_select,
   output logic        rsp_last_of_run,
   output logic [1:0]  rsp_status
);

   // Chip select state: high while a frame waits for data items
   logic             frame_open_ff, frame_open_in;
   logic             frame_open_next;
   dsf_pkg::run_type run;
   logic             ready;
   logic             accept;

   assign req_stall = ~ready;
   assign accept    = req_valid & ready;

   // Build the whole byte run of the item in one pass against the current frame state
   dsf_header u_header (
      .mode          (req_mode),
      .buffer_sel    (req_buffer_sel),
      .page          (req_page),
      .byte_addr     (req_byte_addr),
      .data_byte     (req_data_byte),
      .end_of_frame  (req_end_of_frame),
      .frame_open    (frame_open_ff),
      .run           (run),
      .frame_open_in (frame_open_next)
   );

   // Advance the frame state as soon as the item is taken; later items see it at once
   assign frame_open_in = accept ? frame_open_next : frame_open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
      end
   end

   // Hold the run and send it out byte by byte through the output register
   dsf_emitter u_emitter (
      .clock              (clock),
      .reset              (reset),
      .load               (accept & run.present),
      .run                (run),
      .ready              (ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_spi_byte       (rsp_spi_byte),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_release_select (rsp_release_select),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_status         (rsp_status)
   );

endmodule

/* rtl/dsf_checker.sv */
module dsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_spi_byte,
   input logic       rsp_frame_start,
   input logic       rsp_release_select,
   input logic       rsp_last_of_run,
   input logic [1:0] rsp_status
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_valid_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_release_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_select |-> rsp_last_of_run)
      else $error("chip select released before end of run");

   a_error_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dsf_pkg::STAT_OK |->
         rsp_last_of_run && rsp_spi_byte == 8'h00 && !rsp_frame_start
         && !rsp_release_select)
      else $error("error result has wrong shape");

   a_start_after_close : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_start |-> rsp_status == dsf_pkg::STAT_OK)
      else $error("frame start with error status");

endmodule

bind dataflash_spi_command_framer dsf_checker u_dsf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_spi_byte       (rsp_spi_byte),
   .rsp_frame_start    (rsp_frame_start),
   .rsp_release_select (rsp_release_select),
   .rsp_last_of_run    (rsp_last_of_run),
   .rsp_status         (rsp_status)
);

/* sim/tb.sv */
module tb;

   // Mode codes beyond data are undefined: the block swallows them silently
   localparam logic [3:0] MODE_UNDEF_LO = 4'd12;
   localparam logic [3:0] MODE_UNDEF_HI = 4'd15;
   localparam int         LONG_HOLD     = 300;
   localparam int         DRAIN_CYCLES  = 20;

   // One command or data item as offered on the req channel
   typedef struct {
      logic [3:0]  mode;
      logic        buffer_sel;
      logic [11:0] page;
      logic [9:0]  byte_addr;
      logic [7:0]  data_byte;
      logic        end_of_frame;
   } flash_cmd_type;

   // One byte of the SPI stream as it should leave on the rsp channel
   typedef struct {
      logic [7:0]          spi_byte;
      logic                frame_start;
      logic                release_select;
      logic                last_of_run;
      dsf_pkg::status_type status;
   } spi_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_mode = '0;
   logic        req_buffer_sel = 1'b0;
   logic [11:0] req_page = '0;
   logic [9:0]  req_byte_addr = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_end_of_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_spi_byte;
   logic        rsp_frame_start;
   logic        rsp_release_select;
   logic        rsp_last_of_run;
   logic [1:0]  rsp_status;

   flash_cmd_type  pending_cmds[$];
   spi_beat_type   expected_beats[$];
   flash_cmd_type  next_cmd;
   logic           item_taken = 1'b0;
   logic           frame_is_open = 1'b0;

   int          req_idle_pct = 33;
   int          rsp_stall_pct = 64;
   int          holds_asked = 0;
   int          holds_served = 0;
   int          hold_left = 0;

   int          mismatches = 0;
   int          items_taken = 0;
   int          beats_checked = 0;
   int          error_beats = 0;

   dataflash_spi_command_framer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_buffer_sel     (req_buffer_sel),
      .req_page           (req_page),
      .req_byte_addr      (req_byte_addr),
      .req_data_byte      (req_data_byte),
      .req_end_of_frame   (req_end_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_spi_byte       (rsp_spi_byte),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_release_select (rsp_release_select),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_status         (rsp_status)
   );

   always #10 clock = ~clock;

   // Work out the SPI bytes an accepted item must produce and queue them.
   // Tracks whether chip select is currently held low.
   task automatic frame_spi_bytes(input flash_cmd_type c);
      logic [7:0]   hdr[dsf_pkg::HdrBytes];
      logic [7:0]   p1, p0, ah, al;
      int           n;
      bit           stays_open;
      spi_beat_type b;
      p1 = {2'b00, c.page[11:6]};
      p0 = {c.page[5:0], 2'b00};
      ah = {6'b0, c.byte_addr[9:8]};
      al = c.byte_addr[7:0];
      n = 0;
      stays_open = 1'b0;
      // undefined modes: nothing comes out and the frame state holds
      if (c.mode > dsf_pkg::MODE_DATA) return;
      if (c.mode == dsf_pkg::MODE_DATA) begin
         // data with chip select high is flagged, otherwise pass the byte through
         if (!frame_is_open) begin
            b = '{8'h00, 1'b0, 1'b0, 1'b1, dsf_pkg::STAT_NO_FRAME};
         end else begin
            b = '{c.data_byte, 1'b0, c.end_of_frame, 1'b1, dsf_pkg::STAT_OK};
            if (c.end_of_frame) frame_is_open = 1'b0;
         end
         expected_beats.push_back(b);
         return;
      end
      // a command on top of an open frame is refused; the frame stays open
      if (frame_is_open) begin
         expected_beats.push_back('{8'h00, 1'b0, 1'b0, 1'b1, dsf_pkg::STAT_FRAME_OPEN});
         return;
      end
      case (c.mode)
         dsf_pkg::MODE_STATUS: begin
            hdr[0] = dsf_pkg::OP_STATUS; hdr[1] = dsf_pkg::DUMMY_BYTE; n = 2;
         end
         dsf_pkg::MODE_BUF_WRITE: begin
            hdr[0] = c.buffer_sel ? dsf_pkg::OP_BUF2_WRITE : dsf_pkg::OP_BUF1_WRITE;
            hdr[1] = 8'h00; hdr[2] = ah; hdr[3] = al; n = 4; stays_open = 1'b1;
         end
         dsf_pkg::MODE_BUF_READ: begin
            hdr[0] = c.buffer_sel ? dsf_pkg::OP_BUF2_READ : dsf_pkg::OP_BUF1_READ;
            hdr[1] = 8'h00; hdr[2] = ah; hdr[3] = al; hdr[4] = dsf_pkg::DUMMY_BYTE;
            n = 5; stays_open = 1'b1;
         end
         dsf_pkg::MODE_PAGE_READ: begin
            hdr[0] = dsf_pkg::OP_PAGE_READ; hdr[1] = p1; hdr[2] = p0 | ah; hdr[3] = al;
            n = 4; stays_open = 1'b1;
         end
         dsf_pkg::MODE_PAGE_TO_BUF: begin
            hdr[0] = c.buffer_sel ? dsf_pkg::OP_PG_TO_BUF2 : dsf_pkg::OP_PG_TO_BUF1;
            hdr[1] = p1; hdr[2] = p0; hdr[3] = 8'h00; n = 4;
         end
         dsf_pkg::MODE_BUF_TO_PAGE: begin
            hdr[0] = c.buffer_sel ? dsf_pkg::OP_BUF2_TO_PG : dsf_pkg::OP_BUF1_TO_PG;
            hdr[1] = p1; hdr[2] = p0; hdr[3] = 8'h00; n = 4;
         end
         dsf_pkg::MODE_BUF_TO_PAGE_NE: begin
            hdr[0] = c.buffer_sel ? dsf_pkg::OP_BUF2_TO_PGN : dsf_pkg::OP_BUF1_TO_PGN;
            hdr[1] = p1; hdr[2] = p0; hdr[3] = 8'h00; n = 4;
         end
         dsf_pkg::MODE_PAGE_ERASE: begin
            hdr[0] = dsf_pkg::OP_PAGE_ERASE;
            hdr[1] = p1; hdr[2] = p0; hdr[3] = 8'h00; n = 4;
         end
         dsf_pkg::MODE_BLOCK_ERASE: begin
            hdr[0] = dsf_pkg::OP_BLOCK_ERASE;
            hdr[1] = p1; hdr[2] = p0; hdr[3] = 8'h00; n = 4;
         end
         dsf_pkg::MODE_CHIP_ERASE: begin
            hdr[0] = dsf_pkg::CHIP_ERASE_0; hdr[1] = dsf_pkg::CHIP_ERASE_1;
            hdr[2] = dsf_pkg::CHIP_ERASE_2; hdr[3] = dsf_pkg::CHIP_ERASE_3; n = 4;
         end
         default: begin
            hdr[0] = c.buffer_sel ? dsf_pkg::OP_BUF2_PROG : dsf_pkg::OP_BUF1_PROG;
            hdr[1] = p1; hdr[2] = p0 | ah; hdr[3] = al; n = 4; stays_open = 1'b1;
         end
      endcase
      for (int i = 0; i < n; i++) begin
         b.spi_byte       = hdr[i];
         b.frame_start    = (i == 0);
         b.release_select = (i == n - 1) && !stays_open;
         b.last_of_run    = (i == n - 1);
         b.status         = dsf_pkg::STAT_OK;
         expected_beats.push_back(b);
      end
      frame_is_open = stays_open;
   endtask

   task automatic push_cmd(input logic [3:0] m, input logic s, input logic [11:0] p,
                           input logic [9:0] a, input logic [7:0] d, input logic e);
      flash_cmd_type c;
      c = '{m, s, p, a, d, e};
      pending_cmds.push_back(c);
   endtask

   // Fill the queue with mostly well-formed frames carrying random content,
   // mixed with stray data, refused commands and undefined modes.
   task automatic queue_random_traffic(input int target);
      int         made;
      int         roll;
      int         k;
      logic [3:0] m;
      made = 0;
      while (made < target) begin
         roll = $urandom_range(99);
         if (roll < 80) begin
            m = 4'($urandom_range(dsf_pkg::MODE_BUF_PROG));
            push_cmd(m, 1'($urandom), 12'($urandom), 10'($urandom),
                     8'($urandom), 1'($urandom));
            made++;
            if (m == dsf_pkg::MODE_BUF_WRITE || m == dsf_pkg::MODE_BUF_READ ||
                m == dsf_pkg::MODE_PAGE_READ || m == dsf_pkg::MODE_BUF_PROG) begin
               // hold the frame open for a few data bytes, then release it
               k = $urandom_range(1, 6);
               for (int i = 0; i < k; i++) begin
                  push_cmd(dsf_pkg::MODE_DATA, 1'($urandom), 12'($urandom),
                           10'($urandom), 8'($urandom), i == k - 1);
               end
               made += k;
            end
         end else if (roll < 90) begin
            // stray data byte with chip select high
            push_cmd(dsf_pkg::MODE_DATA, 1'($urandom), 12'($urandom), 10'($urandom),
                     8'($urandom), 1'($urandom));
            made++;
         end else if (roll < 95) begin
            // open a frame, barge in with a command, then close it
            push_cmd(dsf_pkg::MODE_BUF_READ, 1'($urandom), 12'($urandom),
                     10'($urandom), 8'($urandom), 1'($urandom));
            push_cmd(4'($urandom_range(dsf_pkg::MODE_BUF_PROG)), 1'($urandom),
                     12'($urandom), 10'($urandom), 8'($urandom), 1'($urandom));
            push_cmd(dsf_pkg::MODE_DATA, 1'($urandom), 12'($urandom), 10'($urandom),
                     8'($urandom), 1'b1);
            made += 3;
         end else begin
            // undefined mode: ignored by the block, so not counted
            push_cmd(4'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI)), 1'($urandom),
                     12'($urandom), 10'($urandom), 8'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic wait_queue_empty();
      while (pending_cmds.size() != 0) @(negedge clock);
   endtask

   // Driver: advance to the next item only once the current one is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || item_taken)) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            next_cmd = pending_cmds.pop_front();
            req_valid        <= 1'b1;
            req_mode         <= next_cmd.mode;
            req_buffer_sel   <= next_cmd.buffer_sel;
            req_page         <= next_cmd.page;
            req_byte_addr    <= next_cmd.byte_addr;
            req_data_byte    <= next_cmd.data_byte;
            req_end_of_frame <= next_cmd.end_of_frame;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is asked for
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Monitor: check each result taken, then predict for each item taken
   always @(posedge clock) begin
      spi_beat_type want;
      item_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (rsp_status !== dsf_pkg::STAT_OK) error_beats++;
            if (expected_beats.size() == 0) begin
               $error("unexpected result: spi_byte %0h status %0h", rsp_spi_byte,
                      rsp_status);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               check_field("spi_byte", want.spi_byte, rsp_spi_byte);
               check_field("frame_start", 8'(want.frame_start), 8'(rsp_frame_start));
               check_field("release_select", 8'(want.release_select),
                           8'(rsp_release_select));
               check_field("last_of_run", 8'(want.last_of_run), 8'(rsp_last_of_run));
               check_field("status", 8'(want.status), 8'(rsp_status));
            end
         end
         if (req_valid && !req_stall) begin
            items_taken++;
            frame_spi_bytes('{req_mode, req_buffer_sel, req_page, req_byte_addr,
                              req_data_byte, req_end_of_frame});
         end
      end
   end

   // Stimulus and phase control
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: every mode, both buffers for most buffer opcodes, address extremes and each error path
      push_cmd(dsf_pkg::MODE_STATUS,         1'b0, 12'h000, 10'h000, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_BUF_WRITE,      1'b0, 12'h000, 10'h3FF, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_DATA,           1'b0, 12'h000, 10'h000, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_DATA,           1'b1, 12'hFFF, 10'h3FF, 8'hFF, 1'b1);
      push_cmd(dsf_pkg::MODE_BUF_READ,       1'b1, 12'hFFF, 10'h000, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_DATA,           1'b0, 12'h000, 10'h000, 8'hFF, 1'b1);
      push_cmd(dsf_pkg::MODE_PAGE_READ,      1'b0, 12'hFFF, 10'h3FF, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_STATUS,         1'b1, 12'hFFF, 10'h3FF, 8'hFF, 1'b1);
      push_cmd(dsf_pkg::MODE_DATA,           1'b0, 12'h000, 10'h000, 8'hA5, 1'b1);
      push_cmd(dsf_pkg::MODE_PAGE_TO_BUF,    1'b0, 12'h000, 10'h000, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_PAGE_TO_BUF,    1'b1, 12'hFFF, 10'h3FF, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_BUF_TO_PAGE,    1'b0, 12'h123, 10'h155, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_BUF_TO_PAGE,    1'b1, 12'hFFF, 10'h000, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_BUF_TO_PAGE_NE, 1'b0, 12'hABC, 10'h2AA, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_BUF_TO_PAGE_NE, 1'b1, 12'h001, 10'h001, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_PAGE_ERASE,     1'b0, 12'hFFF, 10'h3FF, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_BLOCK_ERASE,    1'b1, 12'h000, 10'h000, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_CHIP_ERASE,     1'b0, 12'h555, 10'h155, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_BUF_PROG,       1'b0, 12'hFFF, 10'h3FF, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_DATA,           1'b0, 12'h000, 10'h000, 8'h5A, 1'b1);
      push_cmd(dsf_pkg::MODE_BUF_PROG,       1'b1, 12'h000, 10'h000, 8'h00, 1'b0);
      push_cmd(dsf_pkg::MODE_DATA,           1'b0, 12'h000, 10'h000, 8'h00, 1'b1);
      push_cmd(dsf_pkg::MODE_DATA,           1'b1, 12'hFFF, 10'h3FF, 8'hC3, 1'b1);
      push_cmd(MODE_UNDEF_LO,                1'b1, 12'hFFF, 10'h3FF, 8'hFF, 1'b1);
      push_cmd(MODE_UNDEF_HI,                1'b0, 12'h000, 10'h000, 8'h00, 1'b0);
      queue_random_traffic(95);
      wait_queue_empty();

      // Swap the idling: sender mostly idle, receiver stalls a third of the time
      req_idle_pct  = 64;
      rsp_stall_pct = 33;
      queue_random_traffic(95);
      wait_queue_empty();

      // No idling; back up the block with a long receiver hold-off
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      queue_random_traffic(40);
      @(negedge clock);
      holds_asked++;
      queue_random_traffic(60);
      wait_queue_empty();

      // Drain: wait for the last item and its results, then let the pipe settle
      do @(negedge clock);
      while (req_valid || expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d items and %0d result bytes, %0d of them error reports.",
               items_taken, beats_checked, error_beats);
      $display("Phases: sender-idle, receiver-stall, and back-to-back with a long hold.");
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
